@@ rtl/core/rlhd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlhd_pkg
// shared constants, codes and word types of the range letter histogram
// distance core
// ----------------------------------------------------------------------------
package rlhd_pkg;

  localparam int MAX_LEN     = 1024;
  localparam int ALPHABET    = 26;

  localparam int CHAR_W      = 5;
  localparam int RANGE_W     = 11;
  localparam int COUNT_W     = 11;

  localparam int LEN_W       = $clog2(MAX_LEN + 1);
  localparam int POS_W       = $clog2(MAX_LEN);
  localparam int LET_W       = $clog2(ALPHABET);
  localparam int DIFF_W      = LEN_W + 1;
  localparam int ACC_W       = LEN_W + 1;
  localparam int MEM_AW      = POS_W + LET_W;
  localparam int MEM_DEPTH   = 1 << MEM_AW;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_APPEND,
    KIND_QUERY,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [CHAR_W-1:0]  char_first;
    logic [CHAR_W-1:0]  char_second;
    logic [RANGE_W-1:0] range_left;
    logic [RANGE_W-1:0] range_right;
  } cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] changes_needed;
    logic               status;
  } result_t;

  typedef struct packed {
    kind_t             kind;
    logic [LET_W-1:0]  letter_first;
    logic [LET_W-1:0]  letter_second;
    logic [POS_W-1:0]  pos_a;
    logic [POS_W-1:0]  pos_b;
    logic              left_first;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } qhead_t;

endpackage

@@ rtl/core/rlhd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlhd_front
// accepts command words, tracks the loaded length and classifies each clear,
// query and in-bounds append into a queue entry for the back end
// ----------------------------------------------------------------------------
module rlhd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  rlhd_pkg::cmd_t cmd,
  output logic           push,
  output rlhd_pkg::op_t  entry
);

  logic [rlhd_pkg::LEN_W-1:0] len;
  logic [rlhd_pkg::LEN_W-1:0] len_next;
  logic                       chars_ok;
  logic                       range_bad;

  assign chars_ok = (32'(cmd.char_first) < rlhd_pkg::ALPHABET) &&
                    (32'(cmd.char_second) < rlhd_pkg::ALPHABET);
  assign range_bad = (cmd.range_left == '0) ||
                     (32'(cmd.range_right) > 32'(len)) ||
                     (cmd.range_left > cmd.range_right);

  always_comb begin
    push                = 1'b0;
    len_next            = len;
    entry.kind          = rlhd_pkg::KIND_CLEAR;
    entry.letter_first  = rlhd_pkg::LET_W'(cmd.char_first);
    entry.letter_second = rlhd_pkg::LET_W'(cmd.char_second);
    entry.pos_a         = rlhd_pkg::POS_W'(cmd.range_right - 1'b1);
    entry.pos_b         = rlhd_pkg::POS_W'(cmd.range_left - 2'd2);
    entry.left_first    = (cmd.range_left == rlhd_pkg::RANGE_W'(1));
    case (cmd.func)
      rlhd_pkg::FUNC_CLEAR: begin
        push     = accept;
        len_next = '0;
      end
      rlhd_pkg::FUNC_APPEND: begin
        entry.kind  = rlhd_pkg::KIND_APPEND;
        entry.pos_a = len[rlhd_pkg::POS_W-1:0];
        if ((32'(len) < rlhd_pkg::MAX_LEN) && chars_ok) begin
          push     = accept;
          len_next = len + 1'b1;
        end
      end
      rlhd_pkg::FUNC_QUERY: begin
        push       = accept;
        entry.kind = range_bad ? rlhd_pkg::KIND_ERROR : rlhd_pkg::KIND_QUERY;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (accept) begin
      len <= len_next;
    end
  end

endmodule

@@ rtl/core/rlhd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlhd_queue
// short fifo of classified operations between front and back end
// ----------------------------------------------------------------------------
module rlhd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rlhd_pkg::op_t   entry,
  input  logic            pop,
  output logic            full,
  output rlhd_pkg::qhead_t head
);

  rlhd_pkg::op_t               entries [rlhd_pkg::QUEUE_DEPTH];
  logic [rlhd_pkg::QPTR_W-1:0] wr_ptr;
  logic [rlhd_pkg::QPTR_W-1:0] rd_ptr;
  logic [rlhd_pkg::QCNT_W-1:0] count;

  assign full       = (32'(count) == rlhd_pkg::QUEUE_DEPTH);
  assign head.valid = (count != '0);
  assign head.op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + rlhd_pkg::QCNT_W'(push) - rlhd_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= entry;
    end
  end

endmodule

@@ rtl/core/rlhd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlhd_back
// executes queued operations: running letter differences, prefix table
// writes on append, and the letter-by-letter distance sum on query
// ----------------------------------------------------------------------------
module rlhd_back (
  input  logic              clk,
  input  logic              rst,
  input  rlhd_pkg::qhead_t  head,
  output logic              pop,
  output logic              done,
  output rlhd_pkg::result_t result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_LAST,
    S_OUT
  } state_t;

  state_t                              state;
  logic [rlhd_pkg::LET_W-1:0]          k;
  logic [rlhd_pkg::POS_W-1:0]          pos_a;
  logic [rlhd_pkg::POS_W-1:0]          pos_b;
  logic                                left_first;
  logic                                rd_vld;
  logic [rlhd_pkg::ACC_W-1:0]          acc;
  logic signed [rlhd_pkg::DIFF_W-1:0]  running [rlhd_pkg::ALPHABET];

  logic [rlhd_pkg::DIFF_W-1:0]         mem [rlhd_pkg::MEM_DEPTH];
  logic                                wr_en;
  logic                                rd_en;
  logic [rlhd_pkg::MEM_AW-1:0]         addr_a;
  logic [rlhd_pkg::MEM_AW-1:0]         addr_b;
  logic [rlhd_pkg::DIFF_W-1:0]         rd_a;
  logic [rlhd_pkg::DIFF_W-1:0]         rd_b;
  logic signed [rlhd_pkg::DIFF_W:0]    diff;
  logic [rlhd_pkg::DIFF_W:0]           mag;

  assign pop    = (state == S_IDLE) && head.valid;
  assign wr_en  = (state == S_WRITE);
  assign rd_en  = (state == S_READ);
  assign addr_a = {pos_a, k};
  assign addr_b = {pos_b, k};

  // prefix at left minus one is zero when the range starts at the first position
  assign diff = signed'({rd_a[rlhd_pkg::DIFF_W-1], rd_a}) -
                (left_first ? '0 : signed'({rd_b[rlhd_pkg::DIFF_W-1], rd_b}));
  assign mag  = diff[rlhd_pkg::DIFF_W] ? unsigned'(-diff) : unsigned'(diff);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_a] <= running[k];
    end
    if (rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      k      <= '0;
      rd_vld <= 1'b0;
      done   <= 1'b0;
      acc    <= '0;
      for (int i = 0; i < rlhd_pkg::ALPHABET; i++) begin
        running[i] <= '0;
      end
    end else begin
      done   <= 1'b0;
      rd_vld <= (state == S_READ);
      if (rd_vld) begin
        acc <= acc + rlhd_pkg::ACC_W'(mag);
      end
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            pos_a      <= head.op.pos_a;
            pos_b      <= head.op.pos_b;
            left_first <= head.op.left_first;
            k          <= '0;
            case (head.op.kind)
              rlhd_pkg::KIND_CLEAR: begin
                for (int i = 0; i < rlhd_pkg::ALPHABET; i++) begin
                  running[i] <= '0;
                end
              end
              rlhd_pkg::KIND_APPEND: begin
                for (int i = 0; i < rlhd_pkg::ALPHABET; i++) begin
                  running[i] <= running[i]
                    + rlhd_pkg::DIFF_W'(i == 32'(head.op.letter_second))
                    - rlhd_pkg::DIFF_W'(i == 32'(head.op.letter_first));
                end
                state <= S_WRITE;
              end
              rlhd_pkg::KIND_QUERY: begin
                acc   <= '0;
                state <= S_READ;
              end
              default: begin
                done                  <= 1'b1;
                result.changes_needed <= '0;
                result.status         <= rlhd_pkg::STATUS_RANGE;
              end
            endcase
          end
        end
        S_WRITE: begin
          k <= k + 1'b1;
          if (32'(k) == rlhd_pkg::ALPHABET - 1) begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          k <= k + 1'b1;
          if (32'(k) == rlhd_pkg::ALPHABET - 1) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= S_OUT;
        end
        S_OUT: begin
          done                  <= 1'b1;
          result.changes_needed <= rlhd_pkg::COUNT_W'(acc >> 1);
          result.status         <= rlhd_pkg::STATUS_OK;
          state                 <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_rd_after_read: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state) == S_READ)
    else $error("read data valid without a read cycle");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == rlhd_pkg::STATUS_RANGE) |-> result.changes_needed == '0)
    else $error("range error word carries a nonzero count");

  a_letter_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE || state == S_READ) |-> 32'(k) < rlhd_pkg::ALPHABET)
    else $error("letter index past alphabet");

  a_out_order: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> $past(state) == S_LAST)
    else $error("result state entered out of order");

endmodule

@@ rtl/core/range_letter_histogram_distance_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_letter_histogram_distance_core
// per-position letter difference table of two strings with range queries
// for the number of changes that make the sorted substrings equal
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; a two-entry
// queue lets commands be taken while earlier ones still run, and busy rises
// only when that queue is full. A clear only resets the running letter
// differences in the back end, an append updates them and then writes one
// prefix table entry per letter through the single write port, and a query
// reads one table pair per letter and then forms the sum. A query with a bad
// range answers without any table read, with status set and a zero count.
// Appends past the maximum length or with a letter outside the alphabet and
// the unused command code give no result. Each result word shows on result
// for exactly one cycle with done high and must be taken then.
module range_letter_histogram_distance_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rlhd_pkg::cmd_t    cmd,
  output logic              done,
  output rlhd_pkg::result_t result
);

  logic             accept;
  logic             push;
  logic             pop;
  logic             full;
  rlhd_pkg::op_t    entry;
  rlhd_pkg::qhead_t head;

  assign busy   = full;
  assign accept = start && !busy;

  rlhd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .push   (push),
    .entry  (entry)
  );

  rlhd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .entry (entry),
    .pop   (pop),
    .full  (full),
    .head  (head)
  );

  rlhd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule

@@ sim/tb_range_letter_histogram_distance_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_letter_histogram_distance_core
// self-checking bench for the range letter histogram distance core: a short
// directed table, then random string pairs with range queries, a fill to the
// maximum length and noise words, all scored against an in-bench letter
// table model with random start gaps and full drains
// ----------------------------------------------------------------------------
module tb_range_letter_histogram_distance_core;
  import rlhd_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int N_DIRECTED   = 23;
  localparam int N_RANDOM     = 600;
  localparam int SHORT_LEN    = 64;

  typedef struct {
    cmd_t    word;
    bit      typed;
    result_t answer;
  } stim_row_t;

  logic    clk;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd   = '0;
  logic    busy;
  logic    done;
  result_t result;

  result_t   pending_answers [$];
  stim_row_t directed_rows [N_DIRECTED];
  result_t   want;
  int        errors;
  int        cycle_count;
  int        idle_pct;
  int        random_words;
  int        span;

  int model_len;
  int running_diff [ALPHABET];
  int prefix_diff [MAX_LEN][ALPHABET];

  range_letter_histogram_distance_core dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic cmd_t make_word(func_t f, int c1, int c2, int left, int right);
    cmd_t c;
    c.func        = f;
    c.char_first  = c1[CHAR_W-1:0];
    c.char_second = c2[CHAR_W-1:0];
    c.range_left  = left[RANGE_W-1:0];
    c.range_right = right[RANGE_W-1:0];
    return c;
  endfunction

  function automatic stim_row_t dir_row(func_t f, int c1, int c2, int left, int right,
                                        bit typed, int count, logic st);
    stim_row_t r;
    r.word                  = make_word(f, c1, c2, left, right);
    r.typed                 = typed;
    r.answer.changes_needed = count[COUNT_W-1:0];
    r.answer.status         = st;
    return r;
  endfunction

  // letter difference table update and range distance
  function automatic void step_letter_tables(input cmd_t c, output bit has_answer,
                                             output result_t answer);
    int total;
    int d;
    int lo;
    int hi;
    has_answer = 1'b0;
    answer     = '0;
    total      = 0;
    lo         = int'(c.range_left);
    hi         = int'(c.range_right);
    case (c.func)
      FUNC_CLEAR: begin
        model_len = 0;
        foreach (running_diff[k]) running_diff[k] = 0;
      end
      FUNC_APPEND: begin
        if (model_len < MAX_LEN && c.char_first < ALPHABET && c.char_second < ALPHABET) begin
          running_diff[c.char_first]  -= 1;
          running_diff[c.char_second] += 1;
          foreach (running_diff[k]) prefix_diff[model_len][k] = running_diff[k];
          model_len++;
        end
      end
      FUNC_QUERY: begin
        has_answer = 1'b1;
        if (lo < 1 || hi > model_len || lo > hi) begin
          answer.status = STATUS_RANGE;
        end else begin
          for (int k = 0; k < ALPHABET; k++) begin
            d = prefix_diff[hi-1][k] - ((lo > 1) ? prefix_diff[lo-2][k] : 0);
            total += (d < 0) ? -d : d;
          end
          answer.changes_needed = COUNT_W'(total / 2);
          answer.status         = STATUS_OK;
        end
      end
      default: ;
    endcase
  endfunction

  // called at a rising edge; returns at the edge that takes the word
  task automatic send_word(cmd_t c, bit typed, result_t typed_answer);
    bit      has_answer;
    result_t answer;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      cmd   <= cmd_t'({$urandom, $urandom});
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    step_letter_tables(c, has_answer, answer);
    if (has_answer) pending_answers.push_back(typed ? typed_answer : answer);
  endtask

  task automatic send_plain(cmd_t c);
    send_word(c, 1'b0, '0);
  endtask

  task automatic drain_answers();
    start <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  function automatic int pick_letter();
    return $urandom_range(0, span - 1);
  endfunction

  task automatic send_random_query();
    int left;
    int right;
    if (model_len > 0 && $urandom_range(0, 99) < 85) begin
      left  = $urandom_range(1, model_len);
      right = $urandom_range(left, model_len);
    end else begin
      case ($urandom_range(0, 3))
        0: begin left = 0; right = $urandom_range(0, model_len); end
        1: begin left = 1; right = model_len + $urandom_range(1, 3); end
        2: begin left = $urandom_range(2, 40); right = left - 1; end
        default: begin left = $urandom_range(0, 2047); right = $urandom_range(0, 2047); end
      endcase
    end
    send_plain(make_word(FUNC_QUERY, pick_letter(), pick_letter(), left, right));
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected result word: expected none actual %0d/%0d",
                 $time, result.changes_needed, result.status);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (result.changes_needed !== want.changes_needed) begin
          $display("%0t changes_needed mismatch: expected %0d actual %0d",
                   $time, want.changes_needed, result.changes_needed);
          errors++;
        end
        if (result.status !== want.status) begin
          $display("%0t status mismatch: expected %0d actual %0d",
                   $time, want.status, result.status);
          errors++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_range_letter_histogram_distance_core: done, errors");
    $finish;
  end

  initial begin
    int r;
    int c1;
    errors       = 0;
    idle_pct     = 25;
    random_words = 0;
    span         = ALPHABET;
    model_len    = 0;
    foreach (running_diff[k]) running_diff[k] = 0;

    directed_rows = '{
      dir_row(FUNC_QUERY,   0,  0,    1,    1, 1, 0, STATUS_RANGE),
      dir_row(FUNC_QUERY,   0,  0,    0,    0, 1, 0, STATUS_RANGE),
      dir_row(FUNC_APPEND,  0, 25,    0,    0, 0, 0, STATUS_OK),
      dir_row(FUNC_APPEND, 25,  0,    0,    0, 0, 0, STATUS_OK),
      dir_row(FUNC_APPEND,  3,  3,    0,    0, 0, 0, STATUS_OK),
      dir_row(FUNC_NONE,   31, 31, 2047, 2047, 0, 0, STATUS_OK),
      dir_row(FUNC_APPEND, 26,  0,    1,    1, 0, 0, STATUS_OK),
      dir_row(FUNC_APPEND,  0, 31,    1,    1, 0, 0, STATUS_OK),
      dir_row(FUNC_QUERY,   0,  0,    1,    3, 1, 0, STATUS_OK),
      dir_row(FUNC_QUERY,   0,  0,    1,    1, 0, 0, STATUS_OK),
      dir_row(FUNC_QUERY,   0,  0,    2,    3, 0, 0, STATUS_OK),
      dir_row(FUNC_QUERY,   0,  0,    0,    3, 1, 0, STATUS_RANGE),
      dir_row(FUNC_QUERY,   0,  0,    1,    4, 1, 0, STATUS_RANGE),
      dir_row(FUNC_QUERY,   0,  0,    3,    2, 1, 0, STATUS_RANGE),
      dir_row(FUNC_QUERY,  31, 31, 2047, 2047, 1, 0, STATUS_RANGE),
      dir_row(FUNC_QUERY,   0,  0,    3,    3, 0, 0, STATUS_OK),
      dir_row(FUNC_CLEAR,   0,  0,    0,    0, 0, 0, STATUS_OK),
      dir_row(FUNC_QUERY,   0,  0,    1,    1, 1, 0, STATUS_RANGE),
      dir_row(FUNC_APPEND, 31, 31,    0,    0, 0, 0, STATUS_OK),
      dir_row(FUNC_QUERY,   0,  0,    1,    1, 1, 0, STATUS_RANGE),
      dir_row(FUNC_APPEND, 12, 13,    0,    0, 0, 0, STATUS_OK),
      dir_row(FUNC_QUERY,   0,  0,    1,    1, 0, 0, STATUS_OK),
      dir_row(FUNC_QUERY,   0,  0,    1, 2047, 1, 0, STATUS_RANGE)
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].answer);
    drain_answers();

    // short string pairs with mostly valid queries
    while (random_words < N_RANDOM) begin
      if (random_words % 100 == 0) idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 15 * $urandom_range(1, 3);
      if (random_words >= N_RANDOM - 100) idle_pct = 0;
      r = $urandom_range(0, 99);
      if (r < 5 || (model_len >= SHORT_LEN && r < 30)) begin
        span = ($urandom_range(0, 1) == 0) ? ALPHABET : 2 << $urandom_range(0, 2);
        send_plain(make_word(FUNC_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom_range(0, 2047), $urandom_range(0, 2047)));
        random_words++;
      end else if (r < 12) begin
        send_plain(cmd_t'({$urandom, $urandom}));
        random_words++;
      end else if (r < 50 && model_len < SHORT_LEN) begin
        c1 = pick_letter();
        send_plain(make_word(FUNC_APPEND, c1, ($urandom_range(0, 2) == 0) ? c1 : pick_letter(),
                             $urandom_range(0, 2047), $urandom_range(0, 2047)));
        random_words++;
      end else begin
        send_random_query();
        random_words++;
      end
      if ($urandom_range(0, 49) == 0) drain_answers();
      if (random_words == N_RANDOM - 100) begin
        drain_answers();

        // fill to the maximum length with disjoint letter sets, then overfill
        idle_pct = 10;
        send_plain(make_word(FUNC_CLEAR, 0, 0, 0, 0));
        for (int i = 0; i < MAX_LEN + 3; i++)
          send_plain(make_word(FUNC_APPEND, $urandom_range(0, 12), $urandom_range(13, 25), 0, 0));
        send_plain(make_word(FUNC_QUERY, 0, 0, 1, MAX_LEN));
        send_plain(make_word(FUNC_QUERY, 0, 0, MAX_LEN, MAX_LEN));
        send_plain(make_word(FUNC_QUERY, 0, 0, 1, MAX_LEN + 1));
        send_plain(make_word(FUNC_QUERY, 0, 0, MAX_LEN / 2, MAX_LEN));
        for (int i = 0; i < 10; i++) send_random_query();
        send_plain(make_word(FUNC_CLEAR, 0, 0, 0, 0));
        drain_answers();
      end
    end

    drain_answers();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("tb_range_letter_histogram_distance_core: done, clean");
    end else begin
      $display("tb_range_letter_histogram_distance_core: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/rlhd_pkg.sv
rtl/core/rlhd_front.sv
rtl/core/rlhd_queue.sv
rtl/core/rlhd_back.sv
rtl/core/range_letter_histogram_distance_core.sv
sim/tb_range_letter_histogram_distance_core.sv
